/* design/gfb_pkg.sv */
// Gammatone filterbank package: payload structs, widths and saturation helpers.
// No dependencies.
package gfb_pkg;

  localparam int AccW = 56;

  typedef struct packed {
    logic              func;
    logic [5:0]        channel_number;
    logic [2:0]        coefficient_slot;
    logic signed [31:0] coefficient_word;
    logic signed [15:0] sample_value;
  } gfb_in_t;

  typedef struct packed {
    logic [5:0]         out_channel;
    logic signed [31:0] filtered_value;
    logic               last_channel;
  } gfb_out_t;

  localparam logic FUNC_COEFF  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(64'sd2147483647);
    lo = AccW'(-64'sd2147483648);
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(64'sd549755813887);
    lo = AccW'(-64'sd549755813888);
    if (v > hi) return 40'sh7fffffffff;
    else if (v < lo) return 40'sh8000000000;
    else return v[39:0];
  endfunction

endpackage

/* design/gfb_mac.sv */
// Shared multiplier: registered 32x32 product, rounded to the signal format.
// Depends on gfb_pkg.
module gfb_mac #(
  parameter int FracBits = 28
) (
  input  logic                            clk_i,
  input  logic signed [31:0]              a_i,
  input  logic signed [31:0]              b_i,
  output logic signed [gfb_pkg::AccW-1:0] rnd_o
);
  import gfb_pkg::*;

  logic signed [63:0] prod_q;
  logic signed [63:0] sum;
  logic signed [63:0] shifted;

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign sum     = prod_q + (64'sd1 <<< (FracBits - 1));
  assign shifted = sum >>> FracBits;
  assign rnd_o   = shifted[AccW-1:0];

endmodule

/* design/gfb_apb.sv */
// APB-style register port holding channels_in_use.
// Depends on nothing beyond the clock and reset.
module gfb_apb (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [6:0]  chan_cnt_o
);
  logic [6:0] chan_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= 7'd32;
    end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
      chan_cnt_q <= pwdata[6:0];
    end
  end

  assign pready     = 1'b1;
  assign prdata     = {25'd0, chan_cnt_q};
  assign chan_cnt_o = chan_cnt_q;

endmodule

/* design/gammatone_filterbank_unit.sv */
// Gammatone filterbank top: sequencer, coefficient and delay memories, output register.
// Per sample, each channel in use is loaded, filtered and presented in turn; the input
// stalls until the last channel is out. The single shared multiplier and the load of
// each channel's coefficients and delays over one memory read port set the throughput.
// Reset clears control state and the per-channel delay valid bits; delays read zero until
// a channel is first processed. Coefficients are undefined until written.
module gammatone_filterbank_unit #(
  parameter int MAX_CHANNELS    = 32,
  parameter int COEFF_FRAC_BITS = 28
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  gfb_pkg::gfb_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output gfb_pkg::gfb_out_t out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import gfb_pkg::*;

  localparam int Depth = MAX_CHANNELS * 8;
  localparam int AddrW = $clog2(Depth);
  localparam int ChW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [5:0] ch_q, ch_d;
  logic [5:0] last_ch_q, last_ch_d;
  logic [3:0] k_q, k_d;
  logic [1:0] sec_q, sec_d;
  logic [2:0] phase_q, phase_d;
  logic [MAX_CHANNELS-1:0] dvalid_q;

  logic signed [15:0] smp_q;
  logic signed [31:0] x_q;
  logic signed [31:0] y_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [31:0] creg_q [8];
  logic signed [39:0] dreg_q [8];

  logic signed [31:0] cmem [Depth];
  logic signed [39:0] dmem [Depth];
  logic signed [31:0] cmem_rd_q;
  logic signed [39:0] dmem_rd_q;

  logic [6:0] chan_cnt;
  logic [6:0] cnt_clamped;
  logic       in_xfer;
  logic       out_free;
  logic [8:0] waddr_full;
  logic [8:0] raddr_full;
  logic [8:0] dwaddr_full;
  logic       dwe;
  logic signed [39:0] dwdata;
  logic signed [31:0] op_a, op_b;
  logic signed [AccW-1:0] rnd;
  logic [2:0] cap_idx;
  logic [2:0] b1_idx;

  gfb_out_t out_q;
  logic     out_valid_q;

  gfb_apb u_apb (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .chan_cnt_o (chan_cnt)
  );

  gfb_mac #(.FracBits(COEFF_FRAC_BITS)) u_mac (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .rnd_o (rnd)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    if (chan_cnt == 7'd0) cnt_clamped = 7'd1;
    else if (chan_cnt > 7'(MAX_CHANNELS)) cnt_clamped = 7'(MAX_CHANNELS);
    else cnt_clamped = chan_cnt;
  end

  assign waddr_full  = {in_data_i.channel_number, in_data_i.coefficient_slot};
  assign raddr_full  = {ch_q, k_q[2:0]};
  assign dwaddr_full = {ch_q, sec_q, (phase_q == 3'd4)};
  assign cap_idx     = 3'(k_q - 4'd1);
  assign b1_idx      = {1'b1, sec_q};

  // coefficient memory
  always_ff @(posedge clk_i) begin
    if (in_xfer && (in_data_i.func == FUNC_COEFF) &&
        ({1'b0, in_data_i.channel_number} < 7'(MAX_CHANNELS))) begin
      cmem[waddr_full[AddrW-1:0]] <= in_data_i.coefficient_word;
    end
    cmem_rd_q <= cmem[raddr_full[AddrW-1:0]];
  end

  // delay memory
  assign dwe = (state_q == ST_CALC) && ((phase_q == 3'd3) || (phase_q == 3'd4));
  always_comb begin
    if (phase_q == 3'd3) dwdata = sat40(acc_q - rnd);
    else dwdata = sat40(-rnd);
  end

  always_ff @(posedge clk_i) begin
    if (dwe) begin
      dmem[dwaddr_full[AddrW-1:0]] <= dwdata;
    end
    dmem_rd_q <= dmem[raddr_full[AddrW-1:0]];
  end

  // multiplier operands
  always_comb begin
    unique case (phase_q)
      3'd0: begin op_a = creg_q[2];      op_b = x_q; end
      3'd1: begin op_a = creg_q[b1_idx]; op_b = x_q; end
      3'd2: begin op_a = creg_q[0];      op_b = y_q; end
      3'd3: begin op_a = creg_q[1];      op_b = y_q; end
      default: begin op_a = creg_q[3];   op_b = y_q; end
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    last_ch_d = last_ch_q;
    k_d       = k_q;
    sec_d     = sec_q;
    phase_d   = phase_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (in_data_i.func == FUNC_SAMPLE)) begin
          state_d   = ST_LOAD;
          ch_d      = 6'd0;
          k_d       = 4'd0;
          last_ch_d = 6'(cnt_clamped - 7'd1);
        end
      end
      ST_LOAD: begin
        k_d = k_q + 4'd1;
        if (k_q == 4'd8) begin
          state_d = ST_CALC;
          sec_d   = 2'd0;
          phase_d = 3'd0;
        end
      end
      ST_CALC: begin
        if (phase_q == 3'd4) begin
          if (sec_q == 2'd3) begin
            state_d = ST_OUT;
          end else begin
            sec_d   = sec_q + 2'd1;
            phase_d = 3'd1;
          end
        end else begin
          phase_d = phase_q + 3'd1;
        end
      end
      default: begin
        if (out_free) begin
          if (ch_q == last_ch_q) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_LOAD;
            ch_d    = ch_q + 6'd1;
            k_d     = 4'd0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= 6'd0;
      last_ch_q   <= 6'd0;
      k_q         <= 4'd0;
      sec_q       <= 2'd0;
      phase_q     <= 3'd0;
      dvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ch_q      <= ch_d;
      last_ch_q <= last_ch_d;
      k_q       <= k_d;
      sec_q     <= sec_d;
      phase_q   <= phase_d;
      if ((state_q == ST_CALC) && (phase_q == 3'd4) && (sec_q == 2'd3)) begin
        dvalid_q[ch_q[ChW-1:0]] <= 1'b1;
      end
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      smp_q <= in_data_i.sample_value;
    end
    if ((state_q == ST_LOAD) && (k_q != 4'd0)) begin
      creg_q[cap_idx] <= cmem_rd_q;
      dreg_q[cap_idx] <= dvalid_q[ch_q[ChW-1:0]] ? dmem_rd_q : 40'sd0;
    end
    if ((state_q == ST_LOAD) && (k_q == 4'd8)) begin
      x_q <= 32'(smp_q) <<< (COEFF_FRAC_BITS - 15);
    end
    if (state_q == ST_CALC) begin
      unique case (phase_q)
        3'd1: y_q <= sat32(rnd + AccW'(dreg_q[{sec_q, 1'b0}]));
        3'd2: acc_q <= rnd + AccW'(dreg_q[{sec_q, 1'b1}]);
        3'd4: x_q <= y_q;
        default: ;
      endcase
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_q.out_channel    <= ch_q;
      out_q.filtered_value <= x_q;
      out_q.last_channel   <= (ch_q == last_ch_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_sample_starts_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_data_i.func == FUNC_SAMPLE) |=> (state_q == ST_LOAD) && in_stall_o)
    else $error("sample transfer did not start a channel load");

  a_channel_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> (ch_q <= last_ch_q))
    else $error("channel counter beyond last channel in use");

  a_out_loaded_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) && out_free |=> out_valid_o)
    else $error("finished channel not presented");
`endif

endmodule

/* dv/gfb_checker.sv */
// Gammatone filterbank checker: watches the sample and result channels and the APB port,
// predicts each channel's four-section output and compares it with what the unit sends.
// Depends on gfb_pkg.
module gfb_checker #(
  parameter int MAX_CHANNELS    = 32,
  parameter int COEFF_FRAC_BITS = 28
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  gfb_pkg::gfb_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  gfb_pkg::gfb_out_t out_data_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [1:0]        paddr_i,
  input  logic [31:0]       pwdata_i,
  output int                fail_count_o,
  output int                pending_o
);
  import gfb_pkg::*;

  localparam int Depth = MAX_CHANNELS * 8;
  localparam longint Max32 = 64'sd2147483647;
  localparam longint Min32 = -64'sd2147483648;
  localparam longint Max40 = 64'sd549755813887;
  localparam longint Min40 = -64'sd549755813888;

  logic [6:0] chan_count;
  longint     coef_mem  [Depth];
  longint     delay_mem [Depth];
  gfb_out_t   filtered_q [$];

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint round_prod(longint c, longint x);
    longint t;
    t = c * x + (64'sd1 <<< (COEFF_FRAC_BITS - 1));
    return t >>> COEFF_FRAC_BITS;
  endfunction

  task automatic filter_sample(input logic signed [15:0] s);
    int n;
    int base;
    longint x, y, b0, b1, a1, a2, d1;
    gfb_out_t r;
    n = (chan_count < 1) ? 1 : ((chan_count > MAX_CHANNELS) ? MAX_CHANNELS : chan_count);
    for (int ch = 0; ch < n; ch++) begin
      base = ch * 8;
      x  = longint'(s) * (64'sd1 <<< (COEFF_FRAC_BITS - 15));
      a1 = coef_mem[base];
      a2 = coef_mem[base + 1];
      for (int sec = 0; sec < 4; sec++) begin
        b0 = (sec == 0) ? coef_mem[base + 2] : coef_mem[base + 3];
        b1 = coef_mem[base + 4 + sec];
        d1 = delay_mem[base + sec * 2 + 1];
        y  = clamp(round_prod(b0, x) + delay_mem[base + sec * 2], Min32, Max32);
        delay_mem[base + sec * 2] =
          clamp(round_prod(b1, x) - round_prod(a1, y) + d1, Min40, Max40);
        delay_mem[base + sec * 2 + 1] = clamp(-round_prod(a2, y), Min40, Max40);
        x = y;
      end
      r.out_channel    = 6'(ch);
      r.filtered_value = 32'(x);
      r.last_channel   = (ch + 1 == n);
      filtered_q.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gfb_out_t want;
    if (!rst_ni) begin
      chan_count = 7'd32;
      for (int i = 0; i < Depth; i++) begin
        coef_mem[i]  = 0;
        delay_mem[i] = 0;
      end
      filtered_q.delete();
      fail_count_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && paddr_i == 2'd0) chan_count = pwdata_i[6:0];
      if (out_valid_i && !out_stall_i) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected result ch %0d value %0d last %0b", $time,
                   out_data_i.out_channel, out_data_i.filtered_value,
                   out_data_i.last_channel);
          fail_count_o++;
        end else begin
          want = filtered_q.pop_front();
          if (want.out_channel !== out_data_i.out_channel) begin
            $display("%0t: channel mismatch exp %0d got %0d", $time,
                     want.out_channel, out_data_i.out_channel);
            fail_count_o++;
          end
          if (want.filtered_value !== out_data_i.filtered_value) begin
            $display("%0t: value mismatch ch %0d exp %0d got %0d", $time,
                     want.out_channel, want.filtered_value, out_data_i.filtered_value);
            fail_count_o++;
          end
          if (want.last_channel !== out_data_i.last_channel) begin
            $display("%0t: last flag mismatch ch %0d exp %0b got %0b", $time,
                     want.out_channel, want.last_channel, out_data_i.last_channel);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.func == FUNC_COEFF) begin
          if (in_data_i.channel_number < MAX_CHANNELS)
            coef_mem[in_data_i.channel_number * 8 + in_data_i.coefficient_slot] =
              longint'(in_data_i.coefficient_word);
        end else begin
          filter_sample(in_data_i.sample_value);
        end
      end
    end
    pending_o = filtered_q.size();
  end

endmodule

/* dv/tb_gammatone_filterbank_unit.sv */
// Testbench top for gammatone_filterbank_unit: clock, reset, sample and coefficient
// stimulus, APB register writes and the verdict. Depends on gfb_pkg and gfb_checker.
module tb_gammatone_filterbank_unit;
  import gfb_pkg::*;

  localparam int WatchdogLimit = 30000;
  localparam int InW = $bits(gfb_in_t);

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  gfb_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  gfb_out_t    out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int   fail_count;
  int   pending_results;
  int   quiet_cycles = 0;
  logic idle_en = 1'b1;
  logic hold_req = 1'b0;

  logic [6:0] chan_settings [8] = '{7'd32, 7'd1, 7'd0, 7'd127, 7'd64, 7'd5, 7'd17, 7'd32};

  gammatone_filterbank_unit DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o, .out_stall_i,
    .out_data_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  gfb_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .fail_count_o(fail_count), .pending_o(pending_results)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        for (int i = 0; i < 2000; i++) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall_i = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk_i);
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic send(input gfb_in_t d);
    if (idle_en && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 10)) @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_coeff(input logic [5:0] ch, input logic [2:0] slot,
                            input logic [31:0] word);
    gfb_in_t d;
    d = gfb_in_t'(InW'({$urandom, $urandom}));
    d.func = FUNC_COEFF;
    d.channel_number = ch;
    d.coefficient_slot = slot;
    d.coefficient_word = word;
    send(d);
  endtask

  task automatic send_sample(input logic [15:0] s);
    gfb_in_t d;
    d = gfb_in_t'(InW'({$urandom, $urandom}));
    d.func = FUNC_SAMPLE;
    d.sample_value = s;
    send(d);
  endtask

  function automatic logic [31:0] rand_coeff();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 2) != 0) w = {{5{w[31]}}, w[26:0]};
    return w;
  endfunction

  function automatic logic [15:0] rand_sample();
    logic [15:0] s;
    s = 16'($urandom);
    if ($urandom_range(0, 3) == 0) s = {{8{s[15]}}, s[7:0]};
    return s;
  endfunction

  task automatic settle();
    while (pending_results != 0) @(posedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data; penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    for (int ch = 0; ch < 32; ch++)
      for (int sl = 0; sl < 8; sl++) send_coeff(6'(ch), 3'(sl), rand_coeff());
    send_coeff(6'd31, 3'd4, 32'h7fffffff);
    send_coeff(6'd31, 3'd5, 32'h80000000);
    send_coeff(6'd30, 3'd2, 32'h7fffffff);
    send_coeff(6'd63, 3'd0, 32'h80000000);
    send_coeff(6'd40, 3'd7, 32'h12345678);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'hffff);
    send_sample(16'h7fff);
    repeat (4) send_sample(16'h0000);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) idle_en = 1'b0;
      if (ph > 0) begin
        settle();
        apb_write(2'd0, {25'($urandom), chan_settings[ph]});
      end
      if (ph == 3) hold_req = 1'b1;
      for (int k = 0; k < 9; k++) begin
        if ($urandom_range(0, 4) == 0)
          send_coeff(6'($urandom), 3'($urandom), rand_coeff());
        send_sample(rand_sample());
      end
    end

    while (pending_results != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
